### hw/rtl/rnpc_pkg.sv
package rnpc_pkg;

	localparam int unsigned PixW   = 16;
	localparam int unsigned WordW  = 32;
	localparam int unsigned ChanW  = 8;
	localparam int unsigned TWidW  = 4;
	localparam int unsigned PosW   = 5;
	localparam int unsigned FmtW   = 3;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 5;
	localparam int unsigned ScaledW = 15;

	typedef enum logic [FmtW-1:0] {
		FMT_R5G6B5      = 3'd0,
		FMT_R5G5B5      = 3'd1,
		FMT_R5G6B5_SWAP = 3'd2,
		FMT_R5G5B5_SWAP = 3'd3,
		FMT_B5G6R5      = 3'd4,
		FMT_B5G5R5      = 3'd5,
		FMT_CUSTOM      = 3'd6
	} fmt_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SRC_FORMAT  = 3'd0,
		REG_RED_WIDTH   = 3'd1,
		REG_GREEN_WIDTH = 3'd2,
		REG_BLUE_WIDTH  = 3'd3,
		REG_RED_POS     = 3'd4,
		REG_GREEN_POS   = 3'd5,
		REG_BLUE_POS    = 3'd6,
		REG_INVERT      = 3'd7
	} reg_idx_t;

	localparam logic [FmtW-1:0]  RstSrcFormat = 3'd0;
	localparam logic [TWidW-1:0] RstRedWidth  = 4'd5;
	localparam logic [TWidW-1:0] RstGreenWidth = 4'd6;
	localparam logic [TWidW-1:0] RstBlueWidth = 4'd5;
	localparam logic [PosW-1:0]  RstRedPos    = 5'd11;
	localparam logic [PosW-1:0]  RstGreenPos  = 5'd5;
	localparam logic [PosW-1:0]  RstBluePos   = 5'd0;

	// Default 5:6:5 source layout
	localparam logic [TWidW-1:0] SrcW5 = 4'd5;
	localparam logic [TWidW-1:0] SrcW6 = 4'd6;
	localparam logic [PosW-1:0]  SrcSh11 = 5'd11;
	localparam logic [PosW-1:0]  SrcSh10 = 5'd10;
	localparam logic [PosW-1:0]  SrcSh5  = 5'd5;
	localparam logic [PosW-1:0]  SrcSh0  = 5'd0;

	typedef struct packed {
		logic [FmtW-1:0]  src_format;
		logic [TWidW-1:0] red_width;
		logic [TWidW-1:0] green_width;
		logic [TWidW-1:0] blue_width;
		logic [PosW-1:0]  red_pos;
		logic [PosW-1:0]  green_pos;
		logic [PosW-1:0]  blue_pos;
		logic             invert;
	} cfg_t;

	typedef struct packed {
		logic [TWidW-1:0] rb;
		logic [TWidW-1:0] gb;
		logic [TWidW-1:0] bb;
		logic [PosW-1:0]  rs;
		logic [PosW-1:0]  gs;
		logic [PosW-1:0]  bs;
		logic             swap;
	} layout_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	function automatic layout_t decode_layout(cfg_t cfg);
		layout_t l;
		l.rb   = SrcW5;
		l.gb   = SrcW6;
		l.bb   = SrcW5;
		l.rs   = SrcSh11;
		l.gs   = SrcSh5;
		l.bs   = SrcSh0;
		l.swap = 1'b0;
		case (cfg.src_format)
			FMT_R5G6B5: begin
			end
			FMT_R5G5B5: begin
				l.gb = SrcW5;
				l.rs = SrcSh10;
			end
			FMT_R5G6B5_SWAP: begin
				l.swap = 1'b1;
			end
			FMT_R5G5B5_SWAP: begin
				l.gb   = SrcW5;
				l.rs   = SrcSh10;
				l.swap = 1'b1;
			end
			FMT_B5G6R5: begin
				l.rs = SrcSh0;
				l.bs = SrcSh11;
			end
			FMT_B5G5R5: begin
				l.gb = SrcW5;
				l.rs = SrcSh0;
				l.bs = SrcSh10;
			end
			default: begin
				l.rb = cfg.red_width;
				l.gb = cfg.green_width;
				l.bb = cfg.blue_width;
				l.rs = cfg.red_pos;
				l.gs = cfg.green_pos;
				l.bs = cfg.blue_pos;
			end
		endcase
		return l;
	endfunction

endpackage

### hw/rtl/rnpc_ctrl.sv
module rnpc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output rnpc_pkg::pipe_en_t en
);

	logic v_s1, v_s2, v_s3, v_s4;

	always_comb begin
		en.s4 = !v_s4 || out_ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s4;

endmodule

### hw/rtl/rnpc_channel.sv
module rnpc_channel (
	input  logic                              clk,
	input  rnpc_pkg::pipe_en_t                en,
	input  logic [rnpc_pkg::PixW-1:0]         pix,
	input  logic [rnpc_pkg::TWidW-1:0]        src_width,
	input  logic [rnpc_pkg::PosW-1:0]         src_shift,
	input  logic [rnpc_pkg::TWidW-1:0]        tgt_width,
	input  logic [rnpc_pkg::PosW-1:0]         tgt_pos,
	input  logic                              invert,
	output logic [rnpc_pkg::WordW-1:0]        placed_s3
);

	logic [rnpc_pkg::ChanW-1:0]   x_s1;
	logic [rnpc_pkg::ScaledW-1:0] f_s2;
	logic [rnpc_pkg::PixW-1:0]    pix_sh;
	logic [rnpc_pkg::TWidW-1:0]   w_sat;
	logic [rnpc_pkg::TWidW-1:0]   fill;
	logic [rnpc_pkg::ChanW-1:0]   mask_w;
	logic [rnpc_pkg::ChanW-1:0]   mask_fill;
	logic [rnpc_pkg::ChanW-1:0]   wide;
	logic [rnpc_pkg::ChanW-1:0]   v;
	logic [rnpc_pkg::ScaledW-1:0] scaled;

	// s1: bring the source field down to bit 0
	assign pix_sh = pix >> src_shift;

	always_ff @(posedge clk) begin
		if (en.s1) x_s1 <= pix_sh[rnpc_pkg::ChanW-1:0];
	end

	// s2: widen to 8 bits, invert, cut or extend to target width
	always_comb begin
		w_sat     = (src_width > 4'd8) ? 4'd8 : src_width;
		fill      = 4'd8 - w_sat;
		mask_w    = 8'hff >> fill;
		mask_fill = 8'hff >> w_sat;
		wide      = ((x_s1 & mask_w) << fill) | (x_s1 & mask_fill);
		v         = wide ^ {rnpc_pkg::ChanW{invert}};
		if (tgt_width == 4'd0)
			scaled = '0;
		else if (tgt_width <= 4'd8)
			scaled = {7'b0, v >> (4'd8 - tgt_width)};
		else
			scaled = {7'b0, v} << (tgt_width - 4'd8);
	end

	always_ff @(posedge clk) begin
		if (en.s2) f_s2 <= scaled;
	end

	// s3: move to target position
	always_ff @(posedge clk) begin
		if (en.s3) placed_s3 <= {17'b0, f_s2} << tgt_pos;
	end

endmodule

### hw/rtl/rnpc_pack.sv
module rnpc_pack (
	input  logic                       clk,
	input  rnpc_pkg::pipe_en_t         en,
	input  logic [rnpc_pkg::WordW-1:0] r_s3,
	input  logic [rnpc_pkg::WordW-1:0] g_s3,
	input  logic [rnpc_pkg::WordW-1:0] b_s3,
	input  logic                       zero,
	input  logic                       dup,
	output logic [rnpc_pkg::WordW-1:0] word_s4
);

	logic [rnpc_pkg::WordW-1:0] c;
	logic [15:0]                hi;
	logic [rnpc_pkg::WordW-1:0] word;

	always_comb begin
		c  = r_s3 | g_s3 | b_s3;
		hi = c[31:16] + c[15:0];
		if (zero)
			word = '0;
		else if (dup)
			word = {hi, c[15:0]};
		else
			word = c;
	end

	always_ff @(posedge clk) begin
		if (en.s4) word_s4 <= word;
	end

endmodule

### hw/rtl/rgb16_to_native_pixel_converter.sv
// Converts one 16-bit source pixel per clock, when not stalled, into a 32-bit
// display word. Four register stages (field extract, widen/invert/scale,
// position shift, pack and duplicate) sustain one item per cycle while out_ready
// does not stall the output. in_ready follows out_ready combinationally through
// the per-stage enables, so a free stage always takes the next item. Write the
// configuration registers only while no item is in flight.
module rgb16_to_native_pixel_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rnpc_pkg::PixW-1:0]     source_pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rnpc_pkg::WordW-1:0]    target_word,
	input  logic                          cfg_we,
	input  logic [rnpc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rnpc_pkg::CfgDataW-1:0] cfg_data
);

	rnpc_pkg::cfg_t             cfg_q;
	rnpc_pkg::layout_t          lay;
	rnpc_pkg::pipe_en_t         en;
	logic [rnpc_pkg::PixW-1:0]  pix;
	logic [rnpc_pkg::WordW-1:0] r_s3, g_s3, b_s3;
	logic [5:0]                 width_sum;
	logic                       zero;
	logic                       dup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_format  <= rnpc_pkg::RstSrcFormat;
			cfg_q.red_width   <= rnpc_pkg::RstRedWidth;
			cfg_q.green_width <= rnpc_pkg::RstGreenWidth;
			cfg_q.blue_width  <= rnpc_pkg::RstBlueWidth;
			cfg_q.red_pos     <= rnpc_pkg::RstRedPos;
			cfg_q.green_pos   <= rnpc_pkg::RstGreenPos;
			cfg_q.blue_pos    <= rnpc_pkg::RstBluePos;
			cfg_q.invert      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rnpc_pkg::REG_SRC_FORMAT:  cfg_q.src_format  <= cfg_data[2:0];
				rnpc_pkg::REG_RED_WIDTH:   cfg_q.red_width   <= cfg_data[3:0];
				rnpc_pkg::REG_GREEN_WIDTH: cfg_q.green_width <= cfg_data[3:0];
				rnpc_pkg::REG_BLUE_WIDTH:  cfg_q.blue_width  <= cfg_data[3:0];
				rnpc_pkg::REG_RED_POS:     cfg_q.red_pos     <= cfg_data;
				rnpc_pkg::REG_GREEN_POS:   cfg_q.green_pos   <= cfg_data;
				rnpc_pkg::REG_BLUE_POS:    cfg_q.blue_pos    <= cfg_data;
				rnpc_pkg::REG_INVERT:      cfg_q.invert      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		lay       = rnpc_pkg::decode_layout(cfg_q);
		pix       = lay.swap ? {source_pixel[7:0], source_pixel[15:8]} : source_pixel;
		width_sum = {2'b0, cfg_q.red_width} + {2'b0, cfg_q.green_width}
		          + {2'b0, cfg_q.blue_width};
		dup       = width_sum <= 6'd16;
		zero      = lay.rb == 4'd0;
	end

	rnpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.en        (en)
	);

	rnpc_channel u_red (
		.clk       (clk),
		.en        (en),
		.pix       (pix),
		.src_width (lay.rb),
		.src_shift (lay.rs),
		.tgt_width (cfg_q.red_width),
		.tgt_pos   (cfg_q.red_pos),
		.invert    (cfg_q.invert),
		.placed_s3 (r_s3)
	);

	rnpc_channel u_green (
		.clk       (clk),
		.en        (en),
		.pix       (pix),
		.src_width (lay.gb),
		.src_shift (lay.gs),
		.tgt_width (cfg_q.green_width),
		.tgt_pos   (cfg_q.green_pos),
		.invert    (cfg_q.invert),
		.placed_s3 (g_s3)
	);

	rnpc_channel u_blue (
		.clk       (clk),
		.en        (en),
		.pix       (pix),
		.src_width (lay.bb),
		.src_shift (lay.bs),
		.tgt_width (cfg_q.blue_width),
		.tgt_pos   (cfg_q.blue_pos),
		.invert    (cfg_q.invert),
		.placed_s3 (b_s3)
	);

	rnpc_pack u_pack (
		.clk     (clk),
		.en      (en),
		.r_s3    (r_s3),
		.g_s3    (g_s3),
		.b_s3    (b_s3),
		.zero    (zero),
		.dup     (dup),
		.word_s4 (target_word)
	);

endmodule

### hw/rtl/rnpc_checker.sv
module rnpc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rnpc_pkg::WordW-1:0] target_word
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target_word))
		else $error("result changed while stalled");

	// a free output stage means the pipeline can take an item
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("in_ready low with output stage free");

	// an item that meets no stall passes stages s1 to s4 and comes out with out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1)
		&& $past(in_valid && in_ready, 4)
		&& $past(out_ready, 3) && $past(out_ready, 2) && $past(out_ready, 1)
		|-> out_valid)
		else $error("item lost in pipeline");

endmodule

bind rgb16_to_native_pixel_converter rnpc_checker u_rnpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.target_word (target_word)
);
